// File: rtl/core/fxm_pkg.sv
package fxm_pkg;

    localparam int CMD_W       = 8;
    localparam int HEAD_W      = 16;
    localparam int GAIN_W      = 10;
    localparam int SPEED_W     = 8;
    localparam int GUARD_BITS  = 8;
    localparam int QUOT_BITS   = 9;   // quotient never reaches 512
    localparam int ANGLE_SHIFT = 14;  // angle unit is 1/(100*2^14) degree
    localparam int ANGLE_W     = 30;  // signed residual angle
    localparam int ATAN_LEN    = 24;

    localparam logic signed [CMD_W-1:0] CMD_LIMIT     = 8'sd100;
    localparam logic signed [CMD_W-1:0] CMD_LIMIT_NEG = -8'sd100;
    localparam logic [HEAD_W-1:0] FULL_TURN     = 16'd36000;
    localparam logic [HEAD_W-1:0] QUARTER_TURN  = 16'd9000;
    localparam logic [HEAD_W-1:0] HALF_TURN     = 16'd18000;
    localparam logic [HEAD_W-1:0] THREE_QUARTER = 16'd27000;
    localparam longint GAIN_Q30 = 64'd652032874;  // CORDIC gain K in Q30
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd256;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;
    localparam int PCT_LIMIT = 100;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef longint t_atan_table [0:ATAN_LEN-1];

    localparam t_atan_table ATAN_UNITS = '{
        73728000, 43524180, 22996981, 11673627, 5859466, 2932591,
        1466653, 733371, 366691, 183346, 91673, 45837,
        22918, 11459, 5730, 2865, 1432, 716,
        358, 179, 90, 45, 22, 11
    };

    typedef struct packed {
        logic signed [CMD_W-1:0] strafe;
        logic signed [CMD_W-1:0] forward;
        logic signed [CMD_W-1:0] turn;
    } t_cmd;

    function automatic logic signed [CMD_W-1:0] clamp_cmd(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W-1:0] r;
        r = v;
        if (v > CMD_LIMIT) r = CMD_LIMIT;
        if (v < CMD_LIMIT_NEG) r = CMD_LIMIT_NEG;
        return r;
    endfunction

endpackage

// File: rtl/core/fxm_if.sv
interface fxm_cmd_if;
    logic        valid;
    logic        ready;
    logic signed [7:0] strafe_cmd;
    logic signed [7:0] forward_cmd;
    logic signed [7:0] turn_cmd;
    logic [15:0] heading_centideg;

    modport source (output valid, strafe_cmd, forward_cmd, turn_cmd, heading_centideg,
                    input ready);
    modport sink   (input valid, strafe_cmd, forward_cmd, turn_cmd, heading_centideg,
                    output ready);
endinterface

interface fxm_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

interface fxm_whl_if;
    logic       valid;
    logic       ready;
    logic [7:0] speed_front_left;
    logic       reverse_front_left;
    logic [7:0] speed_front_right;
    logic       reverse_front_right;
    logic [7:0] speed_back_left;
    logic       reverse_back_left;
    logic [7:0] speed_back_right;
    logic       reverse_back_right;

    modport source (output valid, speed_front_left, reverse_front_left, speed_front_right,
                    reverse_front_right, speed_back_left, reverse_back_left,
                    speed_back_right, reverse_back_right, input ready);
    modport sink   (input valid, speed_front_left, reverse_front_left, speed_front_right,
                    reverse_front_right, speed_back_left, reverse_back_left,
                    speed_back_right, reverse_back_right, output ready);
endinterface

// File: rtl/core/fxm_cordic.sv
module fxm_cordic #(
    parameter int STAGES = 16,
    parameter int FRAC   = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [fxm_pkg::ANGLE_W-1:0]  i_z,
    input  logic [1:0]                          i_quad,
    input  fxm_pkg::t_cmd                       i_cmd,
    output logic                                o_valid,
    output logic signed [FRAC+1:0]              o_cos,
    output logic signed [FRAC+1:0]              o_sin,
    output fxm_pkg::t_cmd                       o_cmd
);
    import fxm_pkg::*;

    localparam int WB = FRAC + GUARD_BITS;
    localparam int XW = WB + 3;
    localparam int CW = FRAC + 2;
    localparam logic signed [XW-1:0] X0 =
        XW'((GAIN_Q30 + (64'sd1 <<< (29 - WB))) >>> (30 - WB));
    localparam logic signed [XW-1:0] HALF_LSB = XW'(64'sd1 <<< (GUARD_BITS - 1));
    localparam logic signed [XW-1:0] ONE      = XW'(64'sd1 <<< FRAC);

    logic signed [XW-1:0]      r_x [0:STAGES];
    logic signed [XW-1:0]      r_y [0:STAGES];
    logic signed [ANGLE_W-1:0] r_z [0:STAGES];
    logic [1:0]                r_q [0:STAGES];
    t_cmd                      r_c [0:STAGES];
    logic                      r_v [0:STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0] <= X0;
            r_y[0] <= '0;
            r_z[0] <= i_z;
            r_q[0] <= i_quad;
            r_c[0] <= i_cmd;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ANGLE_W-1:0] ATN = ANGLE_W'(ATAN_UNITS[i]);
        logic signed [XW-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_en) begin
                if (!r_z[i][ANGLE_W-1]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ATN;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ATN;
                end
                r_q[i+1] <= r_q[i];
                r_c[i+1] <= r_c[i];
            end
        end
    end

    // round off guard bits, clamp to +-1.0, then unfold the quadrant
    logic signed [XW-1:0] xr, yr;
    logic signed [CW-1:0] cr, sr, n_cos, n_sin;

    always_comb begin
        xr = (r_x[STAGES] + HALF_LSB) >>> GUARD_BITS;
        yr = (r_y[STAGES] + HALF_LSB) >>> GUARD_BITS;
        if (xr > ONE) xr = ONE;
        if (xr < -ONE) xr = -ONE;
        if (yr > ONE) yr = ONE;
        if (yr < -ONE) yr = -ONE;
        cr = CW'(xr);
        sr = CW'(yr);
        case (r_q[STAGES])
            QUAD_0: begin n_cos = cr;  n_sin = sr;  end
            QUAD_1: begin n_cos = -sr; n_sin = cr;  end
            QUAD_2: begin n_cos = -cr; n_sin = -sr; end
            QUAD_3: begin n_cos = sr;  n_sin = -cr; end
            default: begin n_cos = cr; n_sin = sr;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[STAGES];
        end
        if (i_en) begin
            o_cos <= n_cos;
            o_sin <= n_sin;
            o_cmd <= r_c[STAGES];
        end
    end

endmodule

// File: rtl/core/fxm_div.sv
module fxm_div #(
    parameter int NW = 40,
    parameter int DW = 30,
    parameter int QB = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic          i_tag,
    output logic          o_valid,
    output logic [QB-1:0] o_quot,
    output logic          o_tag
);
    // restoring division, one quotient bit per stage, top bit first

    logic [NW-1:0] r_n [0:QB-1];
    logic [DW-1:0] r_d [0:QB-1];
    logic [QB-1:0] r_q [0:QB];
    logic          r_t [0:QB];
    logic          r_v [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_n[0] <= i_num;
            r_d[0] <= i_den;
            r_q[0] <= '0;
            r_t[0] <= i_tag;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_bit
        localparam int B = QB - 1 - k;
        logic [NW-1:0] sh;
        logic          fit;
        assign sh  = NW'(r_d[k]) << B;
        assign fit = (r_n[k] >= sh);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_q[k+1] <= {r_q[k][QB-2:0], fit};
                r_t[k+1] <= r_t[k];
            end
        end
        if (k < QB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k+1] <= fit ? (r_n[k] - sh) : r_n[k];
                    r_d[k+1] <= r_d[k];
                end
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_quot  = r_q[QB];
    assign o_tag   = r_t[QB];

endmodule

// File: rtl/core/field_oriented_xdrive_mixer.sv
// Channel   Dir  Handshake              Payload
// i_cmd     in   valid/ready            strafe, forward, turn (s8), heading (u16)
// i_cfg     in   valid/ready (ready=1)  drive_gain, 10 bit Q2.8
// o_whl     out  valid/ready            four wheel speeds (u8) + reverse flags
//
// One request accepted per cycle while the output is not stalled; the path runs
// through the CORDIC stage chain and the pipelined one-bit-per-stage dividers.
// Reset: synchronous active low, clears valid bits, drive_gain back to 1.0.
// Stall: the whole pipeline holds while the output register is full and not
// taken; input ready drops only then. Config writes expected only when idle.
module field_oriented_xdrive_mixer #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fxm_cmd_if.sink   i_cmd,
    fxm_cfg_if.sink   i_cfg,
    fxm_whl_if.source o_whl
);
    import fxm_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int CW  = F + 2;          // Q2.F sine/cosine
    localparam int PW  = CMD_W + CW;     // command x trig product
    localparam int WW  = F + 11;         // signed wheel sum
    localparam int MW  = F + 10;         // wheel magnitude
    localparam int GPW = MW + GAIN_W;    // magnitude x gain
    localparam int NW  = MW + 16;        // divider numerator
    localparam int DW  = MW + 6;         // divider denominator
    localparam logic [MW-1:0] LIMIT = MW'(PCT_LIMIT) << F;

    // global advance: everything moves unless the result is stuck
    logic en;
    assign en = !o_whl.valid || o_whl.ready;
    assign i_cmd.ready = en;

    // drive gain register
    logic [GAIN_W-1:0] r_gain;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            r_gain <= i_cfg.data;
        end
    end

    // stage 1: clamp commands, wrap heading into one turn
    logic              r_v1;
    t_cmd              r_cmd1;
    logic [HEAD_W-1:0] r_head1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_cmd.valid;
        end
        if (en) begin
            r_cmd1.strafe  <= clamp_cmd(i_cmd.strafe_cmd);
            r_cmd1.forward <= clamp_cmd(i_cmd.forward_cmd);
            r_cmd1.turn    <= clamp_cmd(i_cmd.turn_cmd);
            r_head1 <= (i_cmd.heading_centideg >= FULL_TURN) ?
                       (i_cmd.heading_centideg - FULL_TURN) : i_cmd.heading_centideg;
        end
    end

    // quadrant and residual angle for the CORDIC
    logic [1:0]                quad;
    logic [HEAD_W-1:0]         base;
    logic signed [ANGLE_W-1:0] z_in;
    always_comb begin
        if (r_head1 >= THREE_QUARTER) begin
            quad = QUAD_3; base = THREE_QUARTER;
        end else if (r_head1 >= HALF_TURN) begin
            quad = QUAD_2; base = HALF_TURN;
        end else if (r_head1 >= QUARTER_TURN) begin
            quad = QUAD_1; base = QUARTER_TURN;
        end else begin
            quad = QUAD_0; base = '0;
        end
        z_in = ANGLE_W'(r_head1 - base) <<< ANGLE_SHIFT;
    end

    logic                 c_v;
    logic signed [CW-1:0] c_cos, c_sin;
    t_cmd                 c_cmd;

    fxm_cordic #(
        .STAGES (CORDIC_STAGES),
        .FRAC   (F)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_z     (z_in),
        .i_quad  (quad),
        .i_cmd   (r_cmd1),
        .o_valid (c_v),
        .o_cos   (c_cos),
        .o_sin   (c_sin),
        .o_cmd   (c_cmd)
    );

    // stage 3: the four rotation products
    logic                    r_v3;
    logic signed [PW-1:0]    r_xc, r_ys, r_yc, r_xs;
    logic signed [CMD_W-1:0] r_turn3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= c_v;
        end
        if (en) begin
            r_xc    <= PW'(c_cmd.strafe) * PW'(c_cos);
            r_ys    <= PW'(c_cmd.forward) * PW'(c_sin);
            r_yc    <= PW'(c_cmd.forward) * PW'(c_cos);
            r_xs    <= PW'(c_cmd.strafe) * PW'(c_sin);
            r_turn3 <= c_cmd.turn;
        end
    end

    // stage 4: field-oriented vector and X-drive wheel sums
    logic signed [WW-1:0] xa, ya, rr;
    logic signed [WW-1:0] r_w4 [0:3];
    logic                 r_v4;
    assign xa = WW'(r_xc) + WW'(r_ys);
    assign ya = WW'(r_yc) - WW'(r_xs);
    assign rr = WW'(r_turn3) <<< F;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
        if (en) begin
            r_w4[0] <= ya + xa + rr;     // front left
            r_w4[1] <= xa - ya + rr;     // front right
            r_w4[2] <= ya - xa + rr;     // back left
            r_w4[3] <= -ya - xa + rr;    // back right
        end
    end

    // stage 5: magnitudes, directions, largest magnitude
    logic [MW-1:0] mag [0:3];
    logic [MW-1:0] m01, m23;
    logic [MW-1:0] r_mag5 [0:3];
    logic [3:0]    r_neg5;
    logic [MW-1:0] r_max5;
    logic          r_v5;
    for (genvar k = 0; k < 4; k++) begin : g_mag
        assign mag[k] = r_w4[k][WW-1] ? MW'(-r_w4[k]) : MW'(r_w4[k]);
    end
    assign m01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
    assign m23 = (mag[3] > mag[2]) ? mag[3] : mag[2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_mag5[k] <= mag[k];
                r_neg5[k] <= r_w4[k][WW-1];
            end
            r_max5 <= (m23 > m01) ? m23 : m01;
        end
    end

    // stage 6: apply gain; note whether the 100/M scale-down is due
    logic [GPW-1:0] r_prod6 [0:3];
    logic [3:0]     r_neg6;
    logic [MW-1:0]  r_max6;
    logic           r_scaled6;
    logic           r_v6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5;
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_prod6[k] <= GPW'(r_mag5[k]) * GPW'(r_gain);
            end
            r_neg6    <= r_neg5;
            r_max6    <= r_max5;
            r_scaled6 <= (r_max5 > LIMIT);
        end
    end

    // rounded quotient: scaled  floor((p*25 + M*32) / (M*64))
    //                   plain   floor((p + 2^(F+7)) / 2^(F+8))
    logic [DW-1:0] den;
    logic [NW-1:0] num [0:3];
    assign den = r_scaled6 ? (DW'(r_max6) << 6) : (DW'(1) << (F + 8));

    logic [3:0]           d_v;
    logic [3:0]           d_neg;
    logic [QUOT_BITS-1:0] d_q [0:3];

    for (genvar k = 0; k < 4; k++) begin : g_div
        assign num[k] = r_scaled6 ? (NW'(r_prod6[k]) * NW'(25) + (NW'(r_max6) << 5))
                                  : (NW'(r_prod6[k]) + (NW'(1) << (F + 7)));
        fxm_div #(
            .NW (NW),
            .DW (DW),
            .QB (QUOT_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_v6),
            .i_num   (num[k]),
            .i_den   (den),
            .i_tag   (r_neg6[k]),
            .o_valid (d_v[k]),
            .o_quot  (d_q[k]),
            .o_tag   (d_neg[k])
        );
    end

    // output register: saturate, reverse only when actually driving
    logic [SPEED_W-1:0] spd [0:3];
    logic [SPEED_W-1:0] r_speed [0:3];
    logic [3:0]         r_rev;
    logic               r_out_v;
    for (genvar k = 0; k < 4; k++) begin : g_sat
        assign spd[k] = (d_q[k] > QUOT_BITS'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(d_q[k]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d_v[0];
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_speed[k] <= spd[k];
                r_rev[k]   <= d_neg[k] && (spd[k] != '0);
            end
        end
    end

    assign o_whl.valid               = r_out_v;
    assign o_whl.speed_front_left    = r_speed[0];
    assign o_whl.reverse_front_left  = r_rev[0];
    assign o_whl.speed_front_right   = r_speed[1];
    assign o_whl.reverse_front_right = r_rev[1];
    assign o_whl.speed_back_left     = r_speed[2];
    assign o_whl.reverse_back_left   = r_rev[2];
    assign o_whl.speed_back_right    = r_speed[3];
    assign o_whl.reverse_back_right  = r_rev[3];

    // checks
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_v == 4'b0000) || (d_v == 4'b1111))
        else $error("divider lanes out of step");

    a_gain_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_gain == GAIN_RESET))
        else $error("drive gain not restored by reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> r_v1)
        else $error("accepted request lost at entry");

    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_v |-> ((c_cos <= (CW'(1) <<< F)) && (c_cos >= -(CW'(1) <<< F))
              && (c_sin <= (CW'(1) <<< F)) && (c_sin >= -(CW'(1) <<< F))))
        else $error("sine or cosine beyond unity");

    a_coast_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !((r_rev[0] && r_speed[0] == '0) || (r_rev[1] && r_speed[1] == '0)
                   || (r_rev[2] && r_speed[2] == '0) || (r_rev[3] && r_speed[3] == '0)))
        else $error("reverse flagged on a coasting wheel");

endmodule
